>>> hw/rtl/rlse_pkg.sv
`default_nettype none

package rlse_pkg;

  // Number of goods types that a produce accepts; higher codes change nothing.
  localparam int unsigned NumTypes = 3;

  // Operation selector of an input item.
  typedef enum logic [1:0] {
    FUNC_PRODUCE = 2'd0,
    FUNC_CONSUME = 2'd1,
    FUNC_LIST    = 2'd2
  } func_e;

  // What every cell of the chain does at a clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PUSH,
    CELL_POP,
    CELL_ROTATE
  } cell_op_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONSUME,
    ST_LIST,
    ST_REPORT
  } state_e;

  // One run held by a cell.
  typedef struct packed {
    logic [1:0]  run_type;
    logic [31:0] run_quantity;
  } run_t;

  // Control broadcast to every cell.
  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

  // Input item.
  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  goods_kind;
    logic [15:0] amount;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]  entry_type;
    logic [31:0] entry_quantity;
    logic [4:0]  depth_now;
    logic        is_empty;
    logic        shortfall;
    logic        push_dropped;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/rlse_cell.sv
`default_nettype none

// One place of the stack. Cell 0 always holds the top run.
module rlse_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 5
) (
  input  wire logic                    clk_i,
  input  wire rlse_pkg::cell_ctrl_t    ctrl_i,
  input  wire logic [CntW-1:0]         count_i,
  input  wire rlse_pkg::run_t          from_above_i,
  input  wire rlse_pkg::run_t          from_below_i,
  input  wire rlse_pkg::run_t          from_top_i,
  output rlse_pkg::run_t               run_o
);
  import rlse_pkg::*;

  // During a rotation the lowest occupied cell takes the old top run.
  localparam logic [CntW-1:0] WrapCnt = CntW'(Idx + 1);

  run_t run_q;
  run_t run_d;

  // Next content from the neighbors.
  always_comb begin
    run_d = run_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
        run_d = run_q;
      end
      CELL_LOAD: begin
        if (Idx == 0) begin
          run_d = from_above_i;
        end
      end
      CELL_PUSH: begin
        run_d = from_above_i;
      end
      CELL_POP: begin
        run_d = from_below_i;
      end
      CELL_ROTATE: begin
        if (count_i == WrapCnt) begin
          run_d = from_top_i;
        end else begin
          run_d = from_below_i;
        end
      end
      default: begin
        run_d = run_q;
      end
    endcase
  end

  // Payload storage, no reset needed.
  always_ff @(posedge clk_i) begin
    run_q <= run_d;
  end

  assign run_o = run_q;

endmodule

`default_nettype wire

>>> hw/rtl/run_length_stack_engine_top.sv
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid_i/in_ready_o   | in_data_i  (rlse_pkg::in_item_t)
// result   | out       | out_valid_o/out_ready_i | out_data_o (rlse_pkg::out_item_t)
//
// A produce or a zero consume updates the top cell when it is taken, then reports.
// A nonzero consume visits the runs at the top cell in the consume state, popping each one
// it uses up, and when it runs out of runs with units still owed it notes a shortfall.
// A list reports N runs one run per cycle while the result is free, rotating the cell chain;
// a list of an empty stack gives a single empty report.
// After reset the stack is empty; runs are only read below the entry count.
// A stalled result holds the sequencer; a new item is taken only in the idle state.
module run_length_stack_engine_top #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire rlse_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rlse_pkg::out_item_t       out_data_o
);
  import rlse_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);
  localparam logic [7:0]      TypeLim = 8'(NumTypes);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] left_q, left_d;
  logic [15:0]     rem_q, rem_d;
  logic            short_q, short_d;
  logic            drop_q, drop_d;
  logic            out_valid_q;
  out_item_t       out_q, out_d;
  logic            out_load;

  cell_ctrl_t      ctrl;
  run_t            new_run;
  run_t            cell_run [STACK_DEPTH];
  run_t            top;

  logic            nonempty;
  logic            full;
  logic            out_free;
  logic            accept;
  logic            type_ok;
  logic [32:0]     sum;
  logic [CntW+4:0] depth_ext;

  // Chain of cells, cell 0 at the top.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    run_t above;
    run_t below;
    if (i == 0) begin : g_first
      assign above = new_run;
    end else begin : g_mid
      assign above = cell_run[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_run[i+1];
    end
    rlse_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .from_above_i (above),
      .from_below_i (below),
      .from_top_i   (cell_run[0]),
      .run_o        (cell_run[i])
    );
  end

  assign top       = cell_run[0];
  assign nonempty  = count_q != '0;
  assign full      = count_q == FullCnt;
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == ST_IDLE;
  assign accept    = in_valid_i && in_ready_o;
  assign type_ok   = {6'd0, in_data_i.goods_kind} < TypeLim;
  assign sum       = {1'b0, top.run_quantity} + 33'(in_data_i.amount);
  assign depth_ext = {5'd0, count_q};

  // Sequencer: next state, cell control and result assembly.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    left_d   = left_q;
    rem_d    = rem_q;
    short_d  = short_q;
    drop_d   = drop_q;
    ctrl.op  = CELL_HOLD;
    new_run  = top;
    out_load = 1'b0;
    out_d    = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          short_d = 1'b0;
          drop_d  = 1'b0;
          unique case (in_data_i.func)
            FUNC_PRODUCE: begin
              state_d = ST_REPORT;
              if (type_ok) begin
                if (nonempty && top.run_type == in_data_i.goods_kind) begin
                  // Merge into the top run, saturating.
                  new_run.run_quantity = sum[32] ? '1 : sum[31:0];
                  ctrl.op = CELL_LOAD;
                end else if (!full) begin
                  new_run.run_type     = in_data_i.goods_kind;
                  new_run.run_quantity = 32'(in_data_i.amount);
                  ctrl.op = CELL_PUSH;
                  count_d = count_q + OneCnt;
                end else begin
                  drop_d = 1'b1;
                end
              end
            end
            FUNC_CONSUME: begin
              if (in_data_i.amount == '0) begin
                // A zero consume only removes an emptied top run.
                state_d = ST_REPORT;
                if (nonempty && top.run_quantity == '0) begin
                  ctrl.op = CELL_POP;
                  count_d = count_q - OneCnt;
                end
              end else begin
                rem_d   = in_data_i.amount;
                state_d = ST_CONSUME;
              end
            end
            FUNC_LIST: begin
              if (nonempty) begin
                left_d  = count_q;
                state_d = ST_LIST;
              end else begin
                state_d = ST_REPORT;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_CONSUME: begin
        // Take units from the top run; pop it when it is used up, note a shortfall when none is left.
        if (!nonempty) begin
          short_d = 1'b1;
          state_d = ST_REPORT;
        end else if (top.run_quantity > {16'd0, rem_q}) begin
          new_run.run_quantity = top.run_quantity - 32'(rem_q);
          ctrl.op = CELL_LOAD;
          state_d = ST_REPORT;
        end else begin
          rem_d   = rem_q - top.run_quantity[15:0];
          ctrl.op = CELL_POP;
          count_d = count_q - OneCnt;
          if (rem_q == top.run_quantity[15:0]) begin
            state_d = ST_REPORT;
          end
        end
      end

      ST_LIST: begin
        // Report the top run, then rotate the occupied cells by one.
        if (out_free) begin
          out_load             = 1'b1;
          out_d.entry_type     = top.run_type;
          out_d.entry_quantity = top.run_quantity;
          out_d.depth_now      = depth_ext[4:0];
          out_d.is_empty       = 1'b0;
          out_d.shortfall      = 1'b0;
          out_d.push_dropped   = 1'b0;
          out_d.last           = left_q == OneCnt;
          ctrl.op              = CELL_ROTATE;
          left_d               = left_q - OneCnt;
          if (left_q == OneCnt) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_REPORT: begin
        // Single result showing the top run after the step, or an empty report when no run is held.
        if (out_free) begin
          out_load             = 1'b1;
          out_d.entry_type     = nonempty ? top.run_type : '0;
          out_d.entry_quantity = nonempty ? top.run_quantity : '0;
          out_d.depth_now      = depth_ext[4:0];
          out_d.is_empty       = !nonempty;
          out_d.shortfall      = short_q;
          out_d.push_dropped   = drop_q;
          out_d.last           = 1'b1;
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    rem_q   <= rem_d;
    short_q <= short_d;
    drop_q  <= drop_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> tb/rlse_checker.sv
module rlse_checker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire rlse_pkg::in_item_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire rlse_pkg::out_item_t out_data_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlse_pkg::*;

  // Shadow copy of the run stack.
  run_t        shadow_runs [STACK_DEPTH];
  logic [4:0]  shadow_count;

  // Reports the block still owes, oldest first.
  out_item_t   awaited_reports [$];
  out_item_t   oldest_report;
  int unsigned mismatches = 0;
  int unsigned report_index = 0;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Report on the top run, or the empty report when nothing is held.
  function automatic out_item_t top_report(input logic short_f, input logic drop_f);
    out_item_t r;
    r = '0;
    if (shadow_count != 0) begin
      r.entry_type     = shadow_runs[shadow_count - 1].run_type;
      r.entry_quantity = shadow_runs[shadow_count - 1].run_quantity;
    end
    r.depth_now    = shadow_count;
    r.is_empty     = (shadow_count == 0);
    r.shortfall    = short_f;
    r.push_dropped = drop_f;
    r.last         = 1'b1;
    return r;
  endfunction

  // Report on one listed run.
  function automatic out_item_t run_report(input int idx, input logic is_last);
    out_item_t r;
    r = top_report(1'b0, 1'b0);
    r.entry_type     = shadow_runs[idx].run_type;
    r.entry_quantity = shadow_runs[idx].run_quantity;
    r.last           = is_last;
    return r;
  endfunction

  // Apply one accepted item to the shadow stack and queue the reports it causes.
  task automatic advance_stack(input in_item_t item);
    logic [31:0] left;
    logic [32:0] sum;
    logic        short_f;
    logic        drop_f;
    int          i;
    short_f = 1'b0;
    drop_f  = 1'b0;
    i       = int'(shadow_count) - 1;
    case (item.func)
      FUNC_PRODUCE: begin
        if (item.goods_kind < NumTypes) begin
          if (shadow_count != 0 && shadow_runs[i].run_type == item.goods_kind) begin
            // Merge into the top run, saturating the quantity.
            sum = {1'b0, shadow_runs[i].run_quantity} + 33'(item.amount);
            shadow_runs[i].run_quantity = sum[32] ? '1 : sum[31:0];
          end else if (shadow_count < STACK_DEPTH) begin
            shadow_runs[shadow_count].run_type     = item.goods_kind;
            shadow_runs[shadow_count].run_quantity = 32'(item.amount);
            shadow_count++;
          end else begin
            drop_f = 1'b1;
          end
        end
        awaited_reports.push_back(top_report(1'b0, drop_f));
      end
      FUNC_CONSUME: begin
        left = 32'(item.amount);
        if (left == 0) begin
          // A zero consume only pops an empty top run.
          if (shadow_count != 0 && shadow_runs[i].run_quantity == 0) begin
            shadow_count--;
          end
        end else begin
          while (left != 0 && shadow_count != 0) begin
            i = int'(shadow_count) - 1;
            if (shadow_runs[i].run_quantity > left) begin
              shadow_runs[i].run_quantity -= left;
              left = 0;
            end else begin
              left -= shadow_runs[i].run_quantity;
              shadow_count--;
            end
          end
          short_f = (left != 0);
        end
        awaited_reports.push_back(top_report(short_f, 1'b0));
      end
      FUNC_LIST: begin
        if (shadow_count == 0) begin
          awaited_reports.push_back(top_report(1'b0, 1'b0));
        end else begin
          for (i = int'(shadow_count) - 1; i >= 0; i--) begin
            awaited_reports.push_back(run_report(i, i == 0));
          end
        end
      end
      default: begin
        // The unused selector causes nothing.
      end
    endcase
  endtask

  // Field by field comparison of one accepted result.
  task automatic compare_report(input out_item_t got, input out_item_t want);
    if (got.entry_type !== want.entry_type)
      report_mismatch($sformatf("result %0d entry_type %0d, expected %0d",
                                report_index, got.entry_type, want.entry_type));
    if (got.entry_quantity !== want.entry_quantity)
      report_mismatch($sformatf("result %0d entry_quantity %0h, expected %0h",
                                report_index, got.entry_quantity, want.entry_quantity));
    if (got.depth_now !== want.depth_now)
      report_mismatch($sformatf("result %0d depth_now %0d, expected %0d",
                                report_index, got.depth_now, want.depth_now));
    if (got.is_empty !== want.is_empty)
      report_mismatch($sformatf("result %0d is_empty %b, expected %b",
                                report_index, got.is_empty, want.is_empty));
    if (got.shortfall !== want.shortfall)
      report_mismatch($sformatf("result %0d shortfall %b, expected %b",
                                report_index, got.shortfall, want.shortfall));
    if (got.push_dropped !== want.push_dropped)
      report_mismatch($sformatf("result %0d push_dropped %b, expected %b",
                                report_index, got.push_dropped, want.push_dropped));
    if (got.last !== want.last)
      report_mismatch($sformatf("result %0d last %b, expected %b",
                                report_index, got.last, want.last));
  endtask

  // Results are checked before the item of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = '0;
      awaited_reports.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_reports.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing awaited", report_index));
        end else begin
          oldest_report = awaited_reports.pop_front();
          compare_report(out_data_i, oldest_report);
        end
        report_index++;
      end
      if (in_valid_i && in_ready_i) begin
        advance_stack(in_data_i);
      end
      pending_o    <= awaited_reports.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlse_pkg::*;

  localparam int unsigned StackDepth = 16;
  localparam logic [1:0]  FuncUnused = 2'd3;
  localparam logic [1:0]  BadType    = 2'(NumTypes);
  localparam int unsigned RandomItems = 220;
  localparam int unsigned FastStart   = 100;
  localparam int unsigned FastStop    = 140;
  localparam int unsigned HoldAt      = 120;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned CycleLimit  = 3000000;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  logic        no_idle = 1'b0;
  logic        hold_off = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_wait = 0;
  int unsigned fail_count;
  int unsigned pending;

  run_length_stack_engine_top #(
    .STACK_DEPTH (StackDepth)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  rlse_checker #(
    .STACK_DEPTH (StackDepth)
  ) stack_checker (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Idle cycles drawn per item, none during fast stretches.
  function automatic int unsigned idle_cycles(input logic fast);
    return fast ? 0 : $urandom_range(0, 19);
  endfunction

  // Result side: wait a drawn number of cycles after each item, or hold off.
  always @(posedge clk) begin
    if (!rst_ni) begin
      rx_wait = idle_cycles(no_idle);
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rx_wait = idle_cycles(no_idle);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_ready <= (rx_wait == 0) && !hold_off;
    end
  end

  // One long hold-off on the result side so the block backs up its input.
  initial begin
    while (items_sent < HoldAt) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic in_item_t make_item(input logic [1:0] f, input logic [1:0] t,
                                         input logic [15:0] a);
    in_item_t item;
    item.func       = f;
    item.goods_kind = t;
    item.amount     = a;
    return item;
  endfunction

  // Amounts lean toward the extremes and small values.
  function automatic logic [15:0] random_amount();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly produces and small consumes, so the stack grows deep and fills.
  function automatic in_item_t random_item();
    int unsigned pick;
    in_item_t    item;
    pick            = $urandom_range(0, 99);
    item.amount     = random_amount();
    item.goods_kind = 2'($urandom);
    if (pick < 55) begin
      item.func = FUNC_PRODUCE;
      if ($urandom_range(0, 19) != 0) begin
        item.goods_kind = 2'($urandom_range(0, NumTypes - 1));
      end else begin
        item.goods_kind = BadType;
      end
    end else if (pick < 85) begin
      item.func = FUNC_CONSUME;
      if ($urandom_range(0, 1) != 0) item.amount = 16'($urandom_range(0, 40));
    end else if (pick < 97) begin
      item.func = FUNC_LIST;
    end else begin
      item.func = FuncUnused;
    end
    return item;
  endfunction

  // Offer one item after a drawn gap and hold it until it is accepted.
  task automatic send_item(input in_item_t item);
    int unsigned gap;
    gap = idle_cycles(no_idle);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent <= items_sent + 1;
  endtask

  initial begin
    int unsigned i;
    int unsigned counted;
    in_item_t    item;

    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Empty stack cases and the zero-quantity run.
    send_item(make_item(FUNC_LIST, 2'd0, 16'h0000));
    send_item(make_item(FUNC_CONSUME, 2'd0, 16'h0000));
    send_item(make_item(FUNC_CONSUME, 2'd3, 16'hFFFF));
    send_item(make_item(FUNC_PRODUCE, 2'd0, 16'h0000));
    send_item(make_item(FUNC_CONSUME, 2'd0, 16'h0000));
    send_item(make_item(FUNC_PRODUCE, BadType, 16'hFFFF));
    send_item(make_item(FuncUnused, 2'd3, 16'hFFFF));

    // Fill the stack with alternating types, one run of zero among them.
    for (i = 0; i < StackDepth; i++) begin
      item = make_item(FUNC_PRODUCE, 2'(i % NumTypes), 16'($urandom));
      if (i == 0) item.amount = 16'hFFFF;
      if (i == 1) item.amount = 16'h0000;
      send_item(item);
    end

    // Full stack: a new run is dropped, a merge and a bad type are not.
    send_item(make_item(FUNC_PRODUCE, 2'(((StackDepth - 1) % NumTypes + 1) % NumTypes),
                        16'h1234));
    send_item(make_item(FUNC_PRODUCE, 2'((StackDepth - 1) % NumTypes), 16'hFFFF));
    send_item(make_item(FUNC_PRODUCE, BadType, 16'h0001));
    send_item(make_item(FUNC_LIST, 2'd0, 16'h0000));
    send_item(make_item(FUNC_CONSUME, 2'd0, 16'h0001));
    send_item(make_item(FUNC_CONSUME, 2'd0, 16'hFFFF));

    // Random traffic with a stretch of no idling in the middle.
    counted = 0;
    while (counted < RandomItems) begin
      if (counted == FastStart) no_idle <= 1'b1;
      if (counted == FastStop) no_idle <= 1'b0;
      item = random_item();
      send_item(item);
      if (item.func != FuncUnused) counted++;
    end

    // A few closing cases on whatever the stack holds now.
    send_item(make_item(FUNC_LIST, 2'd0, 16'h0000));
    send_item(make_item(FUNC_CONSUME, 2'd0, 16'hFFFF));
    send_item(make_item(FUNC_CONSUME, 2'd0, 16'h0000));
    send_item(make_item(FUNC_PRODUCE, 2'd0, 16'h0000));
    send_item(make_item(FUNC_LIST, 2'd0, 16'h0000));
    in_valid <= 1'b0;

    // Wait for every awaited result, then a few more cycles.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
